// ----- design/cst_pkg.sv -----
// Shared types, widths and helper functions for the circle shape collision test.
// Depends on nothing; every other design file uses it by scoped names.
package cst_pkg;

    // Number formats of the ports
    localparam int FRAC_BITS = 8;
    localparam int POS_BITS  = 24;
    localparam int SIZE_BITS = 12;

    // Internal widths derived from the port formats
    localparam int EXT_BITS  = POS_BITS + 2;              // centers, edges, deltas
    localparam int RAD_BITS  = SIZE_BITS - 1 + FRAC_BITS; // one radius in fixed units
    localparam int RS_BITS   = SIZE_BITS + FRAC_BITS;     // radius sum, clipped magnitudes
    localparam int D2_BITS   = 2 * RS_BITS;               // squared distance on a hit
    localparam int ROOT_BITS = RS_BITS;                   // integer square root
    localparam int Q_BITS    = RAD_BITS + 1;              // rim offset quotient
    localparam int NUM_BITS  = ROOT_BITS + Q_BITS;        // dividend of the rim offset

    localparam logic signed [EXT_BITS:0] POS_MAX =
        (EXT_BITS + 1)'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
    localparam logic signed [EXT_BITS:0] POS_MIN = -POS_MAX - 1;

    typedef logic signed [EXT_BITS-1:0] t_fx;

    // Data that rides along the root and divide chains
    typedef struct packed {
        logic                hit;
        logic                rim;
        t_fx                 base_x;
        t_fx                 base_y;
        logic [RS_BITS-1:0]  mag_x;
        logic [RS_BITS-1:0]  mag_y;
        logic                neg_x;
        logic                neg_y;
        logic [RAD_BITS-1:0] rad;
    } t_side;

    // Square root working state, one digit pair per cell
    typedef struct packed {
        logic [ROOT_BITS:0]   rem;
        logic [ROOT_BITS-1:0] root;
        logic [D2_BITS-1:0]   radicand;
    } t_sqrt;

    // Divide working state for both axes, one quotient bit per cell
    typedef struct packed {
        logic [ROOT_BITS-1:0] dd;
        logic [ROOT_BITS-1:0] rem_x;
        logic [ROOT_BITS-1:0] rem_y;
        logic [Q_BITS-1:0]    lo_x;
        logic [Q_BITS-1:0]    lo_y;
    } t_div;

    // Whole pixels to fixed point
    function automatic t_fx px_to_fx(input logic [SIZE_BITS-1:0] v);
        return t_fx'({v, {FRAC_BITS{1'b0}}});
    endfunction

    // Magnitude, clipped to the widest value that can still hit
    function automatic logic [RS_BITS-1:0] sat_mag(input t_fx v);
        logic [EXT_BITS-1:0] a;
        a = v[EXT_BITS-1] ? EXT_BITS'(-v) : EXT_BITS'(v);
        if (a >= (EXT_BITS'(1) << RS_BITS)) begin
            return '1;
        end
        return a[RS_BITS-1:0];
    endfunction

    function automatic t_fx clamp_fx(input t_fx v, input t_fx lo, input t_fx hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic signed [POS_BITS-1:0] sat_pos(
        input logic signed [EXT_BITS:0] v);
        if (v > POS_MAX) begin
            return POS_MAX[POS_BITS-1:0];
        end
        if (v < POS_MIN) begin
            return POS_MIN[POS_BITS-1:0];
        end
        return v[POS_BITS-1:0];
    endfunction

endpackage

// ----- design/cst_if.sv -----
// Valid/ready channel interfaces for the pair request and the collision result.
// Depends on cst_pkg for the field widths.
interface cst_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [cst_pkg::POS_BITS-1:0]   src_x;
    logic signed [cst_pkg::POS_BITS-1:0]   src_y;
    logic        [cst_pkg::SIZE_BITS-1:0]  src_w;
    logic        [cst_pkg::SIZE_BITS-1:0]  src_h;
    logic                                  src_is_wall;
    logic signed [cst_pkg::POS_BITS-1:0]   tgt_x;
    logic signed [cst_pkg::POS_BITS-1:0]   tgt_y;
    logic        [cst_pkg::SIZE_BITS-1:0]  tgt_w;
    logic        [cst_pkg::SIZE_BITS-1:0]  tgt_h;
    logic                                  tgt_shape;
    logic                                  tgt_is_wall;

    modport source (output valid, src_x, src_y, src_w, src_h, src_is_wall,
                    tgt_x, tgt_y, tgt_w, tgt_h, tgt_shape, tgt_is_wall,
                    input ready);
    modport sink   (input valid, src_x, src_y, src_w, src_h, src_is_wall,
                    tgt_x, tgt_y, tgt_w, tgt_h, tgt_shape, tgt_is_wall,
                    output ready);
endinterface

interface cst_out_if;
    logic                                valid;
    logic                                ready;
    logic                                collided;
    logic signed [cst_pkg::POS_BITS-1:0] contact_x;
    logic signed [cst_pkg::POS_BITS-1:0] contact_y;

    modport source (output valid, collided, contact_x, contact_y, input ready);
    modport sink   (input valid, collided, contact_x, contact_y, output ready);
endinterface

// ----- design/cst_geom.sv -----
// Front end: centers, clamping, squared distances and the hit decision, five stages.
// Depends on cst_pkg and cst_in_if; feeds the first square root cell.
module cst_geom (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    cst_in_if.sink         i_in,
    output logic           o_valid,
    output cst_pkg::t_side o_side,
    output cst_pkg::t_sqrt o_sqrt
);

    logic [4:0] r_valid;

    // Stage 1 registers
    cst_pkg::t_fx r1_ax, r1_ay, r1_cy, r1_bx, r1_by, r1_tx, r1_ty, r1_hx, r1_hy;
    logic [cst_pkg::RS_BITS-1:0]  r1_rs;
    logic [cst_pkg::RAD_BITS-1:0] r1_rad;
    logic                         r1_circ, r1_rect;
    // Stage 2 registers
    cst_pkg::t_fx r2_dx, r2_dy, r2_px, r2_py, r2_ax, r2_ay, r2_cy;
    logic [cst_pkg::RS_BITS-1:0]  r2_rs;
    logic [cst_pkg::RAD_BITS-1:0] r2_rad;
    logic                         r2_circ, r2_rect;
    // Stage 3 registers
    logic [cst_pkg::RS_BITS-1:0]  r3_mx, r3_my, r3_t;
    cst_pkg::t_fx                 r3_bx, r3_by;
    logic                         r3_negx, r3_negy;
    logic [cst_pkg::RAD_BITS-1:0] r3_rad;
    logic                         r3_circ, r3_act;
    // Stage 4 registers
    logic [cst_pkg::D2_BITS-1:0]  r4_sqx, r4_sqy, r4_sqt;
    logic [cst_pkg::RS_BITS-1:0]  r4_mx, r4_my;
    cst_pkg::t_fx                 r4_bx, r4_by;
    logic                         r4_negx, r4_negy;
    logic [cst_pkg::RAD_BITS-1:0] r4_rad;
    logic                         r4_circ, r4_act;
    // Stage 5 registers
    cst_pkg::t_side               r_side;
    cst_pkg::t_sqrt               r_sqrt;

    logic [cst_pkg::SIZE_BITS-2:0] ra, rb;
    logic [cst_pkg::RS_BITS-1:0]   n3_mx, n3_my, n3_t;
    cst_pkg::t_fx                  n3_bx, n3_by;
    logic                          n3_negx, n3_negy;
    logic [cst_pkg::D2_BITS:0]     d2;
    logic                          hit;

    assign i_in.ready = i_en;
    assign o_valid    = r_valid[4];
    assign o_side     = r_side;
    assign o_sqrt     = r_sqrt;

    assign ra = i_in.src_w[cst_pkg::SIZE_BITS-1:1];
    assign rb = i_in.tgt_w[cst_pkg::SIZE_BITS-1:1];

    // Pick the distance terms for the circle or the box test
    always_comb begin
        if (r2_circ) begin
            n3_mx   = cst_pkg::sat_mag(r2_dx);
            n3_my   = cst_pkg::sat_mag(r2_dy);
            n3_t    = r2_rs;
            n3_bx   = r2_ax;
            n3_by   = r2_ay;
            n3_negx = r2_dx[cst_pkg::EXT_BITS-1];
            n3_negy = r2_dy[cst_pkg::EXT_BITS-1];
        end else begin
            n3_mx   = cst_pkg::sat_mag(r2_px - r2_ax);
            n3_my   = cst_pkg::sat_mag(r2_py - r2_cy);
            n3_t    = {1'b0, r2_rad};
            n3_bx   = r2_px;
            n3_by   = r2_py;
            n3_negx = 1'b0;
            n3_negy = 1'b0;
        end
    end

    // Compare the squared distance with the squared threshold
    assign d2  = {1'b0, r4_sqx} + {1'b0, r4_sqy};
    assign hit = r4_act && (d2 < {1'b0, r4_sqt});

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_in.valid};
        end
    end

    // Advance the payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax   <= cst_pkg::t_fx'(i_in.src_x) + cst_pkg::px_to_fx({1'b0, ra});
            r1_ay   <= cst_pkg::t_fx'(i_in.src_y)
                       + cst_pkg::px_to_fx({1'b0, i_in.src_h[cst_pkg::SIZE_BITS-1:1]});
            r1_cy   <= cst_pkg::t_fx'(i_in.src_y) + cst_pkg::px_to_fx({1'b0, ra});
            r1_bx   <= cst_pkg::t_fx'(i_in.tgt_x) + cst_pkg::px_to_fx({1'b0, rb});
            r1_by   <= cst_pkg::t_fx'(i_in.tgt_y)
                       + cst_pkg::px_to_fx({1'b0, i_in.tgt_h[cst_pkg::SIZE_BITS-1:1]});
            r1_tx   <= cst_pkg::t_fx'(i_in.tgt_x);
            r1_ty   <= cst_pkg::t_fx'(i_in.tgt_y);
            r1_hx   <= cst_pkg::t_fx'(i_in.tgt_x) + cst_pkg::px_to_fx(i_in.tgt_w);
            r1_hy   <= cst_pkg::t_fx'(i_in.tgt_y) + cst_pkg::px_to_fx(i_in.tgt_h);
            r1_rs   <= {({1'b0, ra} + {1'b0, rb}), {cst_pkg::FRAC_BITS{1'b0}}};
            r1_rad  <= {ra, {cst_pkg::FRAC_BITS{1'b0}}};
            r1_circ <= !i_in.tgt_shape && !i_in.src_is_wall;
            r1_rect <= i_in.tgt_shape && i_in.tgt_is_wall;

            r2_dx   <= r1_bx - r1_ax;
            r2_dy   <= r1_by - r1_ay;
            r2_px   <= cst_pkg::clamp_fx(r1_ax, r1_tx, r1_hx);
            r2_py   <= cst_pkg::clamp_fx(r1_cy, r1_ty, r1_hy);
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_cy   <= r1_cy;
            r2_rs   <= r1_rs;
            r2_rad  <= r1_rad;
            r2_circ <= r1_circ;
            r2_rect <= r1_rect;

            r3_mx   <= n3_mx;
            r3_my   <= n3_my;
            r3_t    <= n3_t;
            r3_bx   <= n3_bx;
            r3_by   <= n3_by;
            r3_negx <= n3_negx;
            r3_negy <= n3_negy;
            r3_rad  <= r2_rad;
            r3_circ <= r2_circ;
            r3_act  <= r2_circ || r2_rect;

            r4_sqx  <= r3_mx * r3_mx;
            r4_sqy  <= r3_my * r3_my;
            r4_sqt  <= r3_t * r3_t;
            r4_mx   <= r3_mx;
            r4_my   <= r3_my;
            r4_bx   <= r3_bx;
            r4_by   <= r3_by;
            r4_negx <= r3_negx;
            r4_negy <= r3_negy;
            r4_rad  <= r3_rad;
            r4_circ <= r3_circ;
            r4_act  <= r3_act;

            r_side.hit      <= hit;
            r_side.rim      <= hit && r4_circ && (d2 != '0);
            r_side.base_x   <= r4_bx;
            r_side.base_y   <= r4_by;
            r_side.mag_x    <= r4_mx;
            r_side.mag_y    <= r4_my;
            r_side.neg_x    <= r4_negx;
            r_side.neg_y    <= r4_negy;
            r_side.rad      <= r4_rad;
            r_sqrt.rem      <= '0;
            r_sqrt.root     <= '0;
            r_sqrt.radicand <= d2[cst_pkg::D2_BITS-1:0];
        end
    end

endmodule

// ----- design/cst_sqrt_cell.sv -----
// One cell of the square root chain: takes two radicand bits, yields one root bit.
// Depends on cst_pkg.
module cst_sqrt_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cst_pkg::t_side i_side,
    input  cst_pkg::t_sqrt i_sqrt,
    output logic           o_valid,
    output cst_pkg::t_side o_side,
    output cst_pkg::t_sqrt o_sqrt
);

    logic                            r_valid;
    cst_pkg::t_side                  r_side;
    cst_pkg::t_sqrt                  r_sqrt;
    cst_pkg::t_sqrt                  n_sqrt;
    logic [cst_pkg::ROOT_BITS+2:0]   acc, trial, diff;

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_sqrt  = r_sqrt;

    // Trial subtract of the next digit pair
    always_comb begin
        acc   = {i_sqrt.rem, i_sqrt.radicand[cst_pkg::D2_BITS-1 -: 2]};
        trial = {1'b0, i_sqrt.root, 2'b01};
        diff  = acc - trial;
        n_sqrt.radicand = {i_sqrt.radicand[cst_pkg::D2_BITS-3:0], 2'b00};
        if (acc >= trial) begin
            n_sqrt.rem  = diff[cst_pkg::ROOT_BITS:0];
            n_sqrt.root = {i_sqrt.root[cst_pkg::ROOT_BITS-2:0], 1'b1};
        end else begin
            n_sqrt.rem  = acc[cst_pkg::ROOT_BITS:0];
            n_sqrt.root = {i_sqrt.root[cst_pkg::ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_sqrt <= n_sqrt;
        end
    end

endmodule

// ----- design/cst_div_cell.sv -----
// One cell of the divide chain: one quotient bit for each axis per cell.
// Depends on cst_pkg.
module cst_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cst_pkg::t_side i_side,
    input  cst_pkg::t_div  i_div,
    output logic           o_valid,
    output cst_pkg::t_side o_side,
    output cst_pkg::t_div  o_div
);

    logic                          r_valid;
    cst_pkg::t_side                r_side;
    cst_pkg::t_div                 r_div;
    cst_pkg::t_div                 n_div;
    logic [cst_pkg::ROOT_BITS:0]   acc_x, acc_y, dvs, dif_x, dif_y;

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_div   = r_div;

    // Shift in the next dividend bit and subtract where it fits
    always_comb begin
        dvs   = {1'b0, i_div.dd};
        acc_x = {i_div.rem_x, i_div.lo_x[cst_pkg::Q_BITS-1]};
        acc_y = {i_div.rem_y, i_div.lo_y[cst_pkg::Q_BITS-1]};
        dif_x = acc_x - dvs;
        dif_y = acc_y - dvs;
        n_div.dd = i_div.dd;
        if (acc_x >= dvs) begin
            n_div.rem_x = dif_x[cst_pkg::ROOT_BITS-1:0];
            n_div.lo_x  = {i_div.lo_x[cst_pkg::Q_BITS-2:0], 1'b1};
        end else begin
            n_div.rem_x = acc_x[cst_pkg::ROOT_BITS-1:0];
            n_div.lo_x  = {i_div.lo_x[cst_pkg::Q_BITS-2:0], 1'b0};
        end
        if (acc_y >= dvs) begin
            n_div.rem_y = dif_y[cst_pkg::ROOT_BITS-1:0];
            n_div.lo_y  = {i_div.lo_y[cst_pkg::Q_BITS-2:0], 1'b1};
        end else begin
            n_div.rem_y = acc_y[cst_pkg::ROOT_BITS-1:0];
            n_div.lo_y  = {i_div.lo_y[cst_pkg::Q_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= i_side;
            r_div  <= n_div;
        end
    end

endmodule

// ----- design/circle_shape_collision_test_unit.sv -----
// Top level of the circle shape collision test: front end, root and divide chains.
// Depends on cst_pkg, cst_if, cst_geom, cst_sqrt_cell and cst_div_cell.
//
//   Port     Dir   Kind            Carries
//   i_in     in    valid/ready     one source/target pair per transaction
//   o_out    out   valid/ready     collided flag and contact point
//
// One transaction is taken per cycle while o_out is not stalled; results leave in order
// through five front stages, 20 root cells, one numerator stage, 20 divide cells and
// the output register.
// Synchronous active-low reset clears all valid bits.
// A result waiting on o_out halts the whole pipeline, and i_in.ready falls with it.
module circle_shape_collision_test_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cst_in_if.sink    i_in,
    cst_out_if.source o_out
);

    logic en;

    logic                 sq_v    [cst_pkg::ROOT_BITS+1];
    cst_pkg::t_side       sq_side [cst_pkg::ROOT_BITS+1];
    cst_pkg::t_sqrt       sq_st   [cst_pkg::ROOT_BITS+1];

    logic                 dv_v    [cst_pkg::Q_BITS+1];
    cst_pkg::t_side       dv_side [cst_pkg::Q_BITS+1];
    cst_pkg::t_div        dv_st   [cst_pkg::Q_BITS+1];

    logic                 r_num_valid;
    cst_pkg::t_side       r_num_side;
    cst_pkg::t_div        r_num_div;

    logic                 r_out_valid;
    logic                 r_out_hit;
    logic signed [cst_pkg::POS_BITS-1:0] r_out_x, r_out_y;

    logic [cst_pkg::ROOT_BITS-1:0] dd;
    logic [cst_pkg::NUM_BITS-1:0]  num_x, num_y;
    logic [cst_pkg::Q_BITS-1:0]    q_x, q_y, q_lim;
    logic signed [cst_pkg::EXT_BITS:0] off_x, off_y, sum_x, sum_y;
    cst_pkg::t_side                fin;

    // Stall everything while a result waits
    assign en = !r_out_valid || o_out.ready;

    cst_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_in    (i_in),
        .o_valid (sq_v[0]),
        .o_side  (sq_side[0]),
        .o_sqrt  (sq_st[0])
    );

    for (genvar g = 0; g < cst_pkg::ROOT_BITS; g++) begin : g_sqrt
        cst_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_side  (sq_side[g]),
            .i_sqrt  (sq_st[g]),
            .o_valid (sq_v[g+1]),
            .o_side  (sq_side[g+1]),
            .o_sqrt  (sq_st[g+1])
        );
    end

    // Form the rounded dividends |delta| * R + D/2
    assign dd    = (sq_st[cst_pkg::ROOT_BITS].root == '0) ? cst_pkg::ROOT_BITS'(1)
                                                       : sq_st[cst_pkg::ROOT_BITS].root;
    assign num_x = cst_pkg::NUM_BITS'(sq_side[cst_pkg::ROOT_BITS].mag_x)
                   * cst_pkg::NUM_BITS'(sq_side[cst_pkg::ROOT_BITS].rad)
                   + cst_pkg::NUM_BITS'(dd >> 1);
    assign num_y = cst_pkg::NUM_BITS'(sq_side[cst_pkg::ROOT_BITS].mag_y)
                   * cst_pkg::NUM_BITS'(sq_side[cst_pkg::ROOT_BITS].rad)
                   + cst_pkg::NUM_BITS'(dd >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_valid <= 1'b0;
        end else if (en) begin
            r_num_valid <= sq_v[cst_pkg::ROOT_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_side      <= sq_side[cst_pkg::ROOT_BITS];
            r_num_div.dd    <= dd;
            r_num_div.rem_x <= num_x[cst_pkg::NUM_BITS-1:cst_pkg::Q_BITS];
            r_num_div.rem_y <= num_y[cst_pkg::NUM_BITS-1:cst_pkg::Q_BITS];
            r_num_div.lo_x  <= num_x[cst_pkg::Q_BITS-1:0];
            r_num_div.lo_y  <= num_y[cst_pkg::Q_BITS-1:0];
        end
    end

    assign dv_v[0]    = r_num_valid;
    assign dv_side[0] = r_num_side;
    assign dv_st[0]   = r_num_div;

    for (genvar g = 0; g < cst_pkg::Q_BITS; g++) begin : g_div
        cst_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_side  (dv_side[g]),
            .i_div   (dv_st[g]),
            .o_valid (dv_v[g+1]),
            .o_side  (dv_side[g+1]),
            .o_div   (dv_st[g+1])
        );
    end

    // Limit offsets to the radius, apply the sign, add to the base point
    always_comb begin
        fin   = dv_side[cst_pkg::Q_BITS];
        q_lim = {1'b0, fin.rad};
        q_x   = (dv_st[cst_pkg::Q_BITS].lo_x > q_lim) ? q_lim : dv_st[cst_pkg::Q_BITS].lo_x;
        q_y   = (dv_st[cst_pkg::Q_BITS].lo_y > q_lim) ? q_lim : dv_st[cst_pkg::Q_BITS].lo_y;
        off_x = '0;
        off_y = '0;
        if (fin.rim) begin
            off_x = fin.neg_x ? -(cst_pkg::EXT_BITS + 1)'(q_x) : (cst_pkg::EXT_BITS + 1)'(q_x);
            off_y = fin.neg_y ? -(cst_pkg::EXT_BITS + 1)'(q_y) : (cst_pkg::EXT_BITS + 1)'(q_y);
        end
        sum_x = (cst_pkg::EXT_BITS + 1)'(fin.base_x) + off_x;
        sum_y = (cst_pkg::EXT_BITS + 1)'(fin.base_y) + off_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_v[cst_pkg::Q_BITS];
        end
    end

    // Hold the result; zero the contact point on a miss
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_hit <= fin.hit;
            r_out_x   <= fin.hit ? cst_pkg::sat_pos(sum_x) : '0;
            r_out_y   <= fin.hit ? cst_pkg::sat_pos(sum_y) : '0;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.collided  = r_out_hit;
    assign o_out.contact_x = r_out_x;
    assign o_out.contact_y = r_out_y;

    // Pipeline empties on reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    // A miss never reports a contact point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.collided) |-> (o_out.contact_x == '0 && o_out.contact_y == '0))
        else $error("nonzero contact point on a miss");

    // No new transaction while the output is stalled
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while output stalled");

endmodule

// ----- bench/circle_shape_collision_test_unit_tb.sv -----
// Self-checking bench for the circle shape collision test unit: random and directed pairs.
// Depends on cst_pkg, cst_if and the unit's top level; predicts each result in 64-bit math.
`timescale 1ns / 1ps

module circle_shape_collision_test_unit_tb;

    localparam int FB       = cst_pkg::FRAC_BITS;
    localparam int PB       = cst_pkg::POS_BITS;
    localparam int LATENCY  = 47;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        logic signed [PB-1:0] src_x;
        logic signed [PB-1:0] src_y;
        logic [11:0]          src_w;
        logic [11:0]          src_h;
        logic                 src_is_wall;
        logic signed [PB-1:0] tgt_x;
        logic signed [PB-1:0] tgt_y;
        logic [11:0]          tgt_w;
        logic [11:0]          tgt_h;
        logic                 tgt_shape;
        logic                 tgt_is_wall;
    } t_pair;

    localparam int PAIR_BITS = $bits(t_pair);

    typedef struct packed {
        logic                 collided;
        logic signed [PB-1:0] contact_x;
        logic signed [PB-1:0] contact_y;
    } t_contact;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cst_in_if  pair_ch ();
    cst_out_if res_ch ();

    circle_shape_collision_test_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pair_ch.sink),
        .o_out  (res_ch.source)
    );

    always #10 i_clk = ~i_clk;

    t_pair    pending_pairs[$];
    t_contact expected_contacts[$];
    int       send_idle_pct = 23;
    int       recv_idle_pct = 67;
    bit       stim_done = 1'b0;
    int       errors = 0;
    int       quiet_cycles = 0;

    // ---------------------------------------------------------------- predictor
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint rim_offset(input longint delta, input longint rad,
                                          input longint unsigned dd);
        longint unsigned mag, q;
        mag = (delta < 0) ? -delta : delta;
        q = (mag * rad + dd / 2) / dd;
        if (q > rad) q = rad;
        return (delta < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic [PB-1:0] clip_pos(input longint v);
        longint hi, lo;
        hi = (64'sd1 <<< (PB - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[PB-1:0];
    endfunction

    function automatic t_contact predict_contact(input t_pair p);
        t_contact res;
        longint sx, sy, tx, ty, ra, rb, acx, acy, bcx, bcy, dx, dy, rs, r;
        longint hx, hy, px, py, cx, cy, ex, ey;
        longint unsigned d2, dd;
        bit hit;
        sx = longint'(p.src_x); sy = longint'(p.src_y);
        tx = longint'(p.tgt_x); ty = longint'(p.tgt_y);
        hit = 1'b0; cx = 0; cy = 0;
        if (!p.tgt_shape) begin
            if (!p.src_is_wall) begin
                ra = longint'(p.src_w / 2); rb = longint'(p.tgt_w / 2);
                acx = sx + (ra <<< FB); acy = sy + (longint'(p.src_h / 2) <<< FB);
                bcx = tx + (rb <<< FB); bcy = ty + (longint'(p.tgt_h / 2) <<< FB);
                dx = bcx - acx; dy = bcy - acy;
                d2 = dx * dx + dy * dy;
                rs = (ra + rb) <<< FB;
                if (d2 < rs * rs) begin
                    hit = 1'b1;
                    if (d2 == 0) begin
                        cx = acx; cy = acy;
                    end else begin
                        dd = floor_sqrt(d2);
                        cx = acx + rim_offset(dx, ra <<< FB, dd);
                        cy = acy + rim_offset(dy, ra <<< FB, dd);
                    end
                end
            end
        end else if (p.tgt_is_wall) begin
            r = longint'(p.src_w / 2) <<< FB;
            acx = sx + r; acy = sy + r;
            hx = tx + (longint'(p.tgt_w) <<< FB); hy = ty + (longint'(p.tgt_h) <<< FB);
            px = acx < tx ? tx : (acx > hx ? hx : acx);
            py = acy < ty ? ty : (acy > hy ? hy : acy);
            ex = px - acx; ey = py - acy;
            if (ex * ex + ey * ey < r * r) begin
                hit = 1'b1; cx = px; cy = py;
            end
        end
        res.collided  = hit;
        res.contact_x = hit ? clip_pos(cx) : '0;
        res.contact_y = hit ? clip_pos(cy) : '0;
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus
    function automatic t_pair random_pair();
        t_pair p;
        int kind;
        p = PAIR_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
        kind = $urandom_range(0, 9);
        // Keep most pairs close and small so hits and rim contacts are common
        if (kind < 7) begin
            p.src_w = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 64));
            p.src_h = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 64));
            p.tgt_w = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 64));
            p.tgt_h = $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 64));
            p.tgt_x = p.src_x + PB'($signed($urandom_range(0, 40000)) - 20000);
            p.tgt_y = p.src_y + PB'($signed($urandom_range(0, 40000)) - 20000);
            if (kind < 5) p.tgt_is_wall = p.tgt_shape;
            if (kind < 4) p.src_is_wall = 1'b0;
        end
        return p;
    endfunction

    function automatic t_pair make_pair(input int sx, input int sy, input int sw, input int sh,
                                        input bit sw_wall, input int tx, input int ty,
                                        input int tw, input int th, input bit shp,
                                        input bit tw_wall);
        t_pair p;
        p.src_x = PB'(sx); p.src_y = PB'(sy); p.src_w = 12'(sw); p.src_h = 12'(sh);
        p.src_is_wall = sw_wall;
        p.tgt_x = PB'(tx); p.tgt_y = PB'(ty); p.tgt_w = 12'(tw); p.tgt_h = 12'(th);
        p.tgt_shape = shp; p.tgt_is_wall = tw_wall;
        return p;
    endfunction

    task automatic wait_drained();
        while (pending_pairs.size() != 0 || expected_contacts.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int mx, mn;
        mx = (1 << (PB - 1)) - 1;
        mn = -(1 << (PB - 1));
        // Directed: overlapping circles, coincident centers, wall source, rectangles
        pending_pairs.push_back(make_pair(0, 0, 20, 20, 0, 2560, 0, 20, 20, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 20, 20, 0, 0, 0, 20, 20, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 20, 20, 1, 100, 100, 20, 20, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 20, 20, 0, 1000, 1000, 10, 10, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 20, 20, 0, 1000, 1000, 10, 10, 1, 0));
        pending_pairs.push_back(make_pair(0, 0, 20, 20, 0, 2560, 2560, 10, 10, 1, 1));
        pending_pairs.push_back(make_pair(mx, mx, 4095, 4095, 0, mx, mx, 4095, 4095, 0, 0));
        pending_pairs.push_back(make_pair(mn, mn, 4095, 4095, 0, mn, mn, 4095, 4095, 0, 0));
        pending_pairs.push_back(make_pair(mx, mx, 4095, 4095, 0, mx - 4096, mx, 4095, 8, 0, 0));
        pending_pairs.push_back(make_pair(mn, mn, 4095, 1, 0, mn, mn + 300, 7, 0, 1, 1));
        pending_pairs.push_back(make_pair(mx, mn, 4095, 4095, 0, mn, mx, 4095, 4095, 1, 1));
        pending_pairs.push_back(make_pair(mx, mx, 4095, 4095, 0, mx - 1000, mx - 1000,
                                          4095, 4095, 1, 1));
        pending_pairs.push_back(make_pair(0, 0, 1, 1, 0, 128, 0, 1, 1, 0, 0));
        pending_pairs.push_back(make_pair(-5000, 300, 30, 3, 0, -4000, 77, 11, 40, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 4095, 4095, 1, 10, 10, 4095, 4095, 1, 1));
        for (int i = 0; i < 280; i++) pending_pairs.push_back(random_pair());
        wait_drained();
        send_idle_pct = 67; recv_idle_pct = 23;
        for (int i = 0; i < 280; i++) pending_pairs.push_back(random_pair());
        wait_drained();
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int i = 0; i < 280; i++) pending_pairs.push_back(random_pair());
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        stim_done = 1'b1;
    end

    // ---------------------------------------------------------------- reset
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------- driver
    initial begin
        pair_ch.valid = 1'b0;
        {pair_ch.src_x, pair_ch.src_y, pair_ch.src_w, pair_ch.src_h, pair_ch.src_is_wall,
         pair_ch.tgt_x, pair_ch.tgt_y, pair_ch.tgt_w, pair_ch.tgt_h, pair_ch.tgt_shape,
         pair_ch.tgt_is_wall} = '0;
        res_ch.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        t_pair p;
        // Retire the accepted transaction and record its expected result
        if (pair_ch.valid && pair_ch.ready) begin
            expected_contacts.push_back(predict_contact(pending_pairs.pop_front()));
        end
        if (!i_rst_n) begin
            pair_ch.valid <= 1'b0;
        end else if (pair_ch.valid && !pair_ch.ready) begin
            // hold the offered item
        end else if (pending_pairs.size() != 0 &&
                     $urandom_range(0, 99) >= send_idle_pct) begin
            p = pending_pairs[0];
            pair_ch.valid       <= 1'b1;
            pair_ch.src_x       <= p.src_x;
            pair_ch.src_y       <= p.src_y;
            pair_ch.src_w       <= p.src_w;
            pair_ch.src_h       <= p.src_h;
            pair_ch.src_is_wall <= p.src_is_wall;
            pair_ch.tgt_x       <= p.tgt_x;
            pair_ch.tgt_y       <= p.tgt_y;
            pair_ch.tgt_w       <= p.tgt_w;
            pair_ch.tgt_h       <= p.tgt_h;
            pair_ch.tgt_shape   <= p.tgt_shape;
            pair_ch.tgt_is_wall <= p.tgt_is_wall;
        end else begin
            pair_ch.valid <= 1'b0;
        end
        res_ch.ready <= i_rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        t_contact want;
        if (res_ch.valid && res_ch.ready) begin
            if (expected_contacts.size() == 0) begin
                $display("%0t: unexpected result collided=%0b x=%0d y=%0d", $time,
                         res_ch.collided, res_ch.contact_x, res_ch.contact_y);
                errors++;
            end else begin
                want = expected_contacts.pop_front();
                if (res_ch.collided !== want.collided) begin
                    $display("%0t: collided expected %0b actual %0b", $time,
                             want.collided, res_ch.collided);
                    errors++;
                end
                if (res_ch.contact_x !== want.contact_x) begin
                    $display("%0t: contact_x expected %0d actual %0d", $time,
                             want.contact_x, res_ch.contact_x);
                    errors++;
                end
                if (res_ch.contact_y !== want.contact_y) begin
                    $display("%0t: contact_y expected %0d actual %0d", $time,
                             want.contact_y, res_ch.contact_y);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- end and watchdog
    always @(posedge i_clk) begin
        if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (stim_done) begin
            if (errors == 0 && expected_contacts.size() == 0) begin
                $display("SUCCESS");
            end else begin
                $display("FAILURE");
            end
            $finish;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
